>>> hdl/sfpa_pkg.sv
// Package: shared constants, opcodes and stage payload types for the fixed-point ALU.
package sfpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QW        = 32 + FRAC_BITS;   // quotient bits, one per divider cell

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_INC  = 4'd4;
    localparam logic [3:0] OP_DEC  = 4'd5;
    localparam logic [3:0] OP_MIN  = 4'd6;
    localparam logic [3:0] OP_MAX  = 4'd7;
    localparam logic [3:0] OP_CMP  = 4'd8;
    localparam logic [3:0] OP_FINT = 4'd9;
    localparam logic [3:0] OP_TINT = 4'd10;

    // Result and flags that ride along the divider chain untouched.
    typedef struct packed {
        logic [31:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
        logic        is_div;
    } t_side;

    // Working state of one restoring division step.
    typedef struct packed {
        logic          neg;
        logic [31:0]   d;
        logic [31:0]   rem;
        logic [QW-1:0] dq;   // dividend bits shift out at the top, quotient bits in at the bottom
    } t_div;

endpackage

>>> hdl/sfpa_front.sv
// Front end: two registered stages that evaluate the simple operations and prepare division.
module sfpa_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_opcode,
    input  logic signed [31:0]    i_operand_a,
    input  logic signed [31:0]    i_operand_b,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sfpa_pkg::t_side       o_side,
    output sfpa_pkg::t_div        o_div
);
    import sfpa_pkg::*;

    localparam logic [63:0] MUL_BIAS = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [32:0] HALF     = (FRAC_BITS > 0) ? (33'd1 << (FRAC_BITS - 1)) : 33'd0;

    // stage 1
    logic               r_v1;
    logic [3:0]         r_op1;
    logic signed [31:0] r_a1, r_b1;
    logic signed [63:0] r_prod1;
    t_side              r_side1;
    t_side              n_side1;
    logic               rdy1;

    // stage 2
    logic  r_v2;
    t_side r_side2;
    t_div  r_div2;
    t_side n_side2;
    t_div  n_div2;
    logic  rdy2;

    logic [32:0]        mag_a;
    logic [32:0]        rnd;
    logic signed [63:0] prod_adj;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        mag_a = i_operand_a[31] ? (33'd0 - {1'b1, i_operand_a}) : {1'b0, i_operand_a};
        rnd   = (mag_a + HALF) >> FRAC_BITS;
        n_side1        = '0;
        n_side1.gt     = i_operand_a > i_operand_b;
        n_side1.lt     = i_operand_a < i_operand_b;
        n_side1.eq     = i_operand_a == i_operand_b;
        n_side1.is_div = i_opcode == OP_DIV;
        n_side1.dz     = (i_opcode == OP_DIV) && (i_operand_b == 32'sd0);
        case (i_opcode)
            OP_ADD:  n_side1.res = i_operand_a + i_operand_b;
            OP_SUB:  n_side1.res = i_operand_a - i_operand_b;
            OP_INC:  n_side1.res = i_operand_a + 32'sd1;
            OP_DEC:  n_side1.res = i_operand_a - 32'sd1;
            OP_MIN:  n_side1.res = (i_operand_a < i_operand_b) ? i_operand_a : i_operand_b;
            OP_MAX:  n_side1.res = (i_operand_a > i_operand_b) ? i_operand_a : i_operand_b;
            OP_FINT: n_side1.res = i_operand_a << FRAC_BITS;
            OP_TINT: n_side1.res = i_operand_a[31] ? (32'd0 - rnd[31:0]) : rnd[31:0];
            default: n_side1.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r_op1   <= i_opcode;
            r_a1    <= i_operand_a;
            r_b1    <= i_operand_b;
            r_prod1 <= 64'(i_operand_a) * 64'(i_operand_b);
            r_side1 <= n_side1;
        end
    end

    always_comb begin
        // truncate toward zero: bias negative products before the shift
        prod_adj = r_prod1 + (r_prod1[63] ? $signed(MUL_BIAS) : 64'sd0);
        n_side2  = r_side1;
        if (r_op1 == OP_MUL) begin
            n_side2.res = 32'(prod_adj >>> FRAC_BITS);
        end
        n_div2.neg = r_a1[31] ^ r_b1[31];
        n_div2.d   = r_b1[31] ? (32'd0 - r_b1) : r_b1;
        n_div2.rem = '0;
        n_div2.dq  = QW'({(r_a1[31] ? (32'd0 - r_a1) : r_a1), {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_side2 <= n_side2;
            r_div2  <= n_div2;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_div   = r_div2;

endmodule

>>> hdl/sfpa_div_cell.sv
// Divider cell: one restoring division step with its own handshake register.
module sfpa_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sfpa_pkg::t_side i_side,
    input  sfpa_pkg::t_div  i_div,
    output logic            o_valid,
    input  logic            i_ready,
    output sfpa_pkg::t_side o_side,
    output sfpa_pkg::t_div  o_div
);
    import sfpa_pkg::*;

    logic        r_vld;
    t_side       r_side;
    t_div        r_div;
    t_div        n_div;
    logic [32:0] trial;
    logic        take;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        trial = {i_div.rem, i_div.dq[QW-1]};
        take  = trial >= {1'b0, i_div.d};
        n_div     = i_div;
        n_div.rem = take ? 32'(trial - {1'b0, i_div.d}) : trial[31:0];
        n_div.dq  = {i_div.dq[QW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_vld;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

>>> hdl/signed_fixed_point_alu_unit.sv
// Top level: signed Q(32-FRAC_BITS).FRAC_BITS fixed-point ALU with a pipelined divider chain.
// Every request takes the same path: two front stages, a chain of 32+FRAC_BITS divider cells
// (one quotient bit per cell, 40 cells at the default FRAC_BITS of 8) and one output register,
// so results leave in request order. One request is accepted every cycle unless every stage
// is full and the output stalls; each stage has its own valid bit and takes a new request
// whenever it is empty or its content moves on, so bubbles collapse and the input stays
// ready while a finished result waits at the output until every stage is full. Multiply truncates
// toward zero, divide by zero returns 0 with divide_by_zero set, all results wrap to 32 bits,
// and the greater/less/equal flags compare the two operands for every opcode.
module signed_fixed_point_alu_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result_value,
    output logic               o_a_greater,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_divide_by_zero
);
    import sfpa_pkg::*;

    // chain links: index 0 is the front end output, index QW the last cell output
    logic  vld [0:QW];
    logic  rdy [0:QW];
    t_side side[0:QW];
    t_div  div [0:QW];

    logic        r_ovld;
    logic [31:0] r_res;
    logic        r_gt, r_lt, r_eq, r_dz;
    logic [31:0] n_res;
    logic        out_rdy;

    sfpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (vld[0]),
        .i_ready     (rdy[0]),
        .o_side      (side[0]),
        .o_div       (div[0])
    );

    for (genvar k = 0; k < QW; k++) begin : g_cell
        sfpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_side  (side[k]),
            .i_div   (div[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_side  (side[k+1]),
            .o_div   (div[k+1])
        );
    end

    // output register: advance whenever it is empty or its result is taken
    assign out_rdy = !r_ovld || i_ready;
    assign rdy[QW] = out_rdy;

    always_comb begin
        // apply the quotient sign here; a zero divisor keeps the 0 set up front
        n_res = side[QW].res;
        if (side[QW].is_div && !side[QW].dz) begin
            n_res = div[QW].neg ? (32'd0 - div[QW].dq[31:0]) : div[QW].dq[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_rdy) begin
            r_ovld <= vld[QW];
        end
        if (out_rdy && vld[QW]) begin
            r_res <= n_res;
            r_gt  <= side[QW].gt;
            r_lt  <= side[QW].lt;
            r_eq  <= side[QW].eq;
            r_dz  <= side[QW].dz;
        end
    end

    assign o_valid          = r_ovld;
    assign o_result_value   = r_res;
    assign o_a_greater      = r_gt;
    assign o_a_less         = r_lt;
    assign o_a_equal        = r_eq;
    assign o_divide_by_zero = r_dz;

endmodule

>>> hdl/sfpa_checker.sv
// Checker: port-level assertions for the fixed-point ALU, bound to the top level.
module sfpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_result_value,
    input logic        o_a_greater,
    input logic        o_a_less,
    input logic        o_a_equal
);

    // hold a stalled result with its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("stalled result changed or dropped");

    // drop input ready only when a result is valid at the output and the output stalls
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused while output can advance");

    // clear the pipeline on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // exactly one ordering flag per result
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_a_greater, o_a_less, o_a_equal}) == 1)
        else $error("compare flags not one-hot");

endmodule

bind signed_fixed_point_alu_unit sfpa_checker u_sfpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_value (o_result_value),
    .o_a_greater    (o_a_greater),
    .o_a_less       (o_a_less),
    .o_a_equal      (o_a_equal)
);

>>> tb/signed_fixed_point_alu_unit_tb.sv
// Testbench for the signed fixed-point ALU: random and directed requests checked in order.
module signed_fixed_point_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfpa_pkg::*;

    localparam int NUM_RANDOM  = 1300;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;

    // One predicted ALU outcome.
    typedef struct {
        logic [31:0] value;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
    } t_alu_outcome;

    // Order-preserving store of predicted ALU outcomes.
    class alu_scoreboard;
        t_alu_outcome pending[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        // Predict the outcome of one accepted request and queue it.
        function void note_request(logic [3:0] op, logic [31:0] a_raw, logic [31:0] b_raw);
            t_alu_outcome o;
            longint a;
            longint b;
            longint scale;
            longint mag;
            a = longint'($signed(a_raw));
            b = longint'($signed(b_raw));
            scale = longint'(1) << FRAC_BITS;
            o.value = '0;
            o.dz = 1'b0;
            case (op)
                OP_ADD:  o.value = 32'(a + b);
                OP_SUB:  o.value = 32'(a - b);
                OP_MUL:  o.value = 32'((a * b) / scale);
                OP_DIV: begin
                    if (b == 0) o.dz = 1'b1;
                    else o.value = 32'((a * scale) / b);
                end
                OP_INC:  o.value = 32'(a + 1);
                OP_DEC:  o.value = 32'(a - 1);
                OP_MIN:  o.value = 32'((a < b) ? a : b);
                OP_MAX:  o.value = 32'((a > b) ? a : b);
                OP_FINT: o.value = 32'(a * scale);
                OP_TINT: begin
                    // round half away from zero on the magnitude
                    mag = (a < 0) ? -a : a;
                    if (FRAC_BITS > 0) mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                    o.value = 32'((a < 0) ? -mag : mag);
                end
                default: o.value = '0;
            endcase
            o.gt = a > b;
            o.lt = a < b;
            o.eq = a == b;
            pending.push_back(o);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [31:0] value, logic gt, logic lt, logic eq, logic dz);
            t_alu_outcome e;
            if (pending.size() == 0) begin
                $error("unexpected result value=%h", value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $error("result_value expected %h actual %h", e.value, value);
                errors++;
            end
            if (gt !== e.gt) begin
                $error("a_greater expected %b actual %b", e.gt, gt);
                errors++;
            end
            if (lt !== e.lt) begin
                $error("a_less expected %b actual %b", e.lt, lt);
                errors++;
            end
            if (eq !== e.eq) begin
                $error("a_equal expected %b actual %b", e.eq, eq);
                errors++;
            end
            if (dz !== e.dz) begin
                $error("divide_by_zero expected %b actual %b", e.dz, dz);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [3:0]         i_opcode;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_result_value;
    logic               o_a_greater;
    logic               o_a_less;
    logic               o_a_equal;
    logic               o_divide_by_zero;

    alu_scoreboard alu_sb;
    int            idle_cycles;
    bit            calm_phase;     // set while neither side idles

    signed_fixed_point_alu_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_opcode    = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        calm_phase  = 1'b0;
        idle_cycles = 0;
        alu_sb      = new();
    end

    // Sample both handshakes at the rising edge; note requests, check results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) alu_sb.note_request(i_opcode, i_operand_a, i_operand_b);
            if (o_valid && i_ready)
                alu_sb.check_result(o_result_value, o_a_greater, o_a_less, o_a_equal,
                                    o_divide_by_zero);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive the result-side ready at the falling edge, stalling at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= calm_phase || ($urandom_range(99) >= 7);
    end

    // Present one request and hold it until accepted.
    task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        while (!calm_phase && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick an operand biased toward edges and small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'($signed($urandom_range(1023)) - 512);
            4: return {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: edges, every opcode, divide by zero, ties, rounding halves, unused codes.
        send_request(OP_ADD,  32'h7fff_ffff, 32'h0000_0001);
        send_request(OP_SUB,  32'h8000_0000, 32'h0000_0001);
        send_request(OP_MUL,  32'h8000_0000, 32'h8000_0000);
        send_request(OP_MUL,  32'hffff_ff80, 32'h0000_0001);
        send_request(OP_DIV,  32'h0000_0300, 32'h0000_0000);
        send_request(OP_DIV,  32'h8000_0000, 32'hffff_ffff);
        send_request(OP_DIV,  32'hffff_fd00, 32'h0000_0200);
        send_request(OP_INC,  32'h7fff_ffff, 32'h0000_0000);
        send_request(OP_DEC,  32'h8000_0000, 32'hffff_ffff);
        send_request(OP_MIN,  32'h0000_0005, 32'h0000_0005);
        send_request(OP_MAX,  32'hffff_fff0, 32'hffff_fff0);
        send_request(OP_MIN,  32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_MAX,  32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_CMP,  32'h0000_0001, 32'h0000_0002);
        send_request(OP_FINT, 32'h00ff_ffff, 32'h0000_0000);
        send_request(OP_FINT, 32'hff80_0000, 32'h0000_0000);
        send_request(OP_TINT, 32'h0000_0180, 32'h0000_0000);
        send_request(OP_TINT, 32'hffff_fe80, 32'h0000_0000);
        send_request(OP_TINT, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_TINT, 32'h7fff_ffff, 32'h0000_0000);
        send_request(4'd11,   32'h1234_5678, 32'h1234_5678);
        send_request(4'd15,   32'hffff_ffff, 32'h0000_0000);

        // Random: mixed phases, one long stretch with no idling on either side.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm_phase = (n >= 400 && n < 700);
            a = pick_operand();
            b = ($urandom_range(9) == 0) ? a : pick_operand();
            send_request(4'($urandom_range(15)), a, b);
        end
        i_valid <= 1'b0;

        // Drain: wait for every prediction, then settle.
        while (alu_sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (alu_sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
